// ----- design/ial_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the slot index allocator.
package ial_pkg;

	localparam int SLOT_W = 10;
	localparam int CAP_W  = 11;
	localparam int STAT_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 2'd0,
		STAT_EXHAUSTED   = 2'd1,
		STAT_NEVER_GIVEN = 2'd2,
		STAT_DOUBLE_FREE = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;   // capture request, launch memory reads
		logic commit;     // apply update, load result register
	} ctrl_t;

endpackage

// ----- design/ial_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine for the slot index allocator.
module ial_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output ial_pkg::ctrl_t  ctrl
);

	ial_pkg::state_t state_q;
	ial_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            res_free;

	// Result register can take a new value when empty or being drained.
	assign res_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ial_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = ial_pkg::ST_EXEC;
			end
			ial_pkg::ST_EXEC: begin
				if (res_free) state_nxt = ial_pkg::ST_IDLE;
			end
			default: state_nxt = ial_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		ctrl.load_req = 1'b0;
		ctrl.commit   = 1'b0;
		unique case (state_q)
			ial_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				ctrl.load_req = in_valid;
			end
			ial_pkg::ST_EXEC: begin
				ctrl.commit = res_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ial_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/ial_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: free list memory, membership bitmap, counters and result register.
module ial_dpath #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ial_pkg::ctrl_t              ctrl,
	input  logic                        command,
	input  logic [ial_pkg::SLOT_W-1:0]  slot,
	input  logic                        cfg_we,
	input  logic [ial_pkg::CAP_W-1:0]   cfg_data,
	output logic [ial_pkg::SLOT_W-1:0]  granted,
	output logic [ial_pkg::STAT_W-1:0]  status
);

	localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
	localparam int ADDR_W   = $clog2(MAX_SLOTS);
	localparam int CMP_W    = (CNT_W > ial_pkg::CAP_W) ? CNT_W : ial_pkg::CAP_W;
	localparam int BM_DEPTH = (MAX_SLOTS < (2 ** ial_pkg::SLOT_W)) ?
		MAX_SLOTS : (2 ** ial_pkg::SLOT_W);
	localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;

	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SLOTS);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

	logic [ial_pkg::CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]           free_count_q;
	logic [CNT_W-1:0]           fresh_next_q;
	logic [ial_pkg::SLOT_W-1:0] front_q;      // free list entry 0
	logic                       cmd_q;
	logic [ial_pkg::SLOT_W-1:0] slot_q;
	logic [ial_pkg::SLOT_W-1:0] granted_q;
	logic [ial_pkg::STAT_W-1:0] status_q;

	// Entries 1..free_count-1 of the free list; entry 0 lives in front_q.
	logic [ial_pkg::SLOT_W-1:0] list_mem [MAX_SLOTS];
	logic [ial_pkg::SLOT_W-1:0] list_rd_q;
	// One bit per slot: set while the slot sits in the free list.
	// Bits at or above fresh_next are stale; cleared when the slot is first issued.
	logic                       bm_mem [BM_DEPTH];
	logic                       bm_rd_q;

	logic [CMP_W-1:0]           cap;
	logic [CNT_W-1:0]           count_m1;

	// Update decisions
	ial_pkg::status_t           res_status;
	logic [ial_pkg::SLOT_W-1:0] res_granted;
	logic                       pop;
	logic                       bump;
	logic                       push;
	logic                       bm_we;
	logic [BM_AW-1:0]           bm_waddr;
	logic                       bm_wdata;

	always_comb begin
		if (CMP_W'(capacity_q) > MAX_CMP) cap = MAX_CMP;
		else cap = CMP_W'(capacity_q);
	end

	assign count_m1 = free_count_q - CNT_W'(1);

	always_comb begin
		res_status  = ial_pkg::STAT_OK;
		res_granted = '0;
		pop         = 1'b0;
		bump        = 1'b0;
		push        = 1'b0;
		bm_we       = 1'b0;
		bm_waddr    = slot_q[BM_AW-1:0];
		bm_wdata    = 1'b0;
		if (cmd_q == ial_pkg::CMD_ALLOC) begin
			if (free_count_q != '0) begin
				if (CMP_W'(front_q) < cap) begin
					res_granted = front_q;
					pop         = 1'b1;
					bm_we       = 1'b1;
					bm_waddr    = front_q[BM_AW-1:0];
				end else begin
					res_status = ial_pkg::STAT_EXHAUSTED;
				end
			end else if (CMP_W'(fresh_next_q) < cap) begin
				res_granted = ial_pkg::SLOT_W'(fresh_next_q);
				bump        = 1'b1;
				bm_we       = 1'b1;
				bm_waddr    = BM_AW'(fresh_next_q);
			end else begin
				res_status = ial_pkg::STAT_EXHAUSTED;
			end
		end else begin
			if (CMP_W'(slot_q) >= CMP_W'(fresh_next_q)) begin
				res_status = ial_pkg::STAT_NEVER_GIVEN;
			end else if (bm_rd_q || free_count_q >= MAX_CNT) begin
				res_status = ial_pkg::STAT_DOUBLE_FREE;
			end else begin
				push     = 1'b1;
				bm_we    = 1'b1;
				bm_wdata = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= ial_pkg::CAP_RESET;
			free_count_q <= '0;
			fresh_next_q <= '0;
		end else begin
			if (cfg_we) capacity_q <= cfg_data;
			if (ctrl.commit) begin
				if (pop) free_count_q <= count_m1;
				else if (push) free_count_q <= free_count_q + CNT_W'(1);
				if (bump) fresh_next_q <= fresh_next_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_req) begin
			cmd_q  <= command;
			slot_q <= slot;
		end
		if (ctrl.commit) begin
			granted_q <= res_granted;
			status_q  <= res_status;
			// last entry moves to the front; meaningless when the list drains
			if (pop) front_q <= list_rd_q;
			else if (push && free_count_q == '0) front_q <= slot_q;
		end
	end

	// Free list memory: read the last entry on request, append on free.
	always_ff @(posedge clk) begin
		if (ctrl.load_req) list_rd_q <= list_mem[count_m1[ADDR_W-1:0]];
		if (ctrl.commit && push && free_count_q != '0)
			list_mem[free_count_q[ADDR_W-1:0]] <= slot_q;
	end

	// Membership bitmap
	always_ff @(posedge clk) begin
		if (ctrl.load_req) bm_rd_q <= bm_mem[BM_AW'(slot)];
		if (ctrl.commit && bm_we) bm_mem[bm_waddr] <= bm_wdata;
	end

	assign granted = granted_q;
	assign status  = status_q;

endmodule

// ----- design/index_allocator_free_list_top.sv -----
`timescale 1ns / 1ps
// Top level of the slot index allocator with free list and bump counter.
//
// Request channel (in_valid / in_stall, command, slot): command 0 allocates
// an index, command 1 returns slot. Each request yields exactly one result
// on the result channel (out_valid / out_stall, granted, status).
// Allocation reuses the front free-list entry, else the next never-used index.
// Status: ok, exhausted, index never handed out, or double free.
// An accepted request's update and result are committed once the result register is free.
// A new request is taken only after the current one commits, set by the read-then-update pass on
// the free list memory and the membership bitmap (one port pair each).
// in_stall is high while each accepted request is being processed; a result
// waiting under out_stall does not block the next request from being taken,
// but its update, and in_stall, wait until the result register frees up.
// Config channel (cfg_valid / cfg_ready, cfg_data) writes capacity; it is
// always ready. Write it only while no request is in flight.
// Reset (arst_n low) empties the free list, zeroes the bump counter and sets
// capacity to 1024. No clearing pass: the block is ready right after reset.
module index_allocator_free_list_top #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [ial_pkg::SLOT_W-1:0]  slot,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ial_pkg::SLOT_W-1:0]  granted,
	output logic [ial_pkg::STAT_W-1:0]  status,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ial_pkg::CAP_W-1:0]   cfg_data
);

	ial_pkg::ctrl_t ctrl;
	logic           cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	ial_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	ial_dpath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.command  (command),
		.slot     (slot),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.granted  (granted),
		.status   (status)
	);

endmodule

// ----- design/ial_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the slot index allocator, bound to the top level.
module ial_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [ial_pkg::SLOT_W-1:0]  granted,
	input logic [ial_pkg::STAT_W-1:0]  status
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted) && $stable(status))
		else $error("result changed while stalled");

	// Failed requests grant zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ial_pkg::STAT_OK |-> granted == '0)
		else $error("nonzero grant on failed request");

	// Only one request in flight.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted back to back");

	// A fresh result always comes from a request accepted in ST_IDLE and committed in ST_EXEC.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a request");

endmodule

bind index_allocator_free_list_top ial_checker u_ial_checker (.*);
